/* rtl/core/firpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firpt_pkg
// shared constants and control types of the programmable-tap fir filter
// ----------------------------------------------------------------------------
package firpt_pkg;

	localparam int TAPS_DEF        = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int TC_W            = 7;
	localparam int IDX_W           = 6;
	localparam int ACC_W           = 64;
	localparam logic [TC_W-1:0] TC_RESET = 7'd4;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_WRITE  = 1'b1;

	typedef struct packed {
		logic rotate;
		logic shift;
	} cell_ctrl_t;

	typedef struct packed {
		logic clear;
		logic mac_en;
	} mac_ctrl_t;

endpackage

/* rtl/core/firpt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firpt_cell
// one tap cell: holds one coefficient and one delayed sample, rotates both
// around the ring or shifts the sample down the delay line
// ----------------------------------------------------------------------------
module firpt_cell #(
	parameter int SAMPLE_BITS = firpt_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  firpt_pkg::cell_ctrl_t         ctl,
	input  logic signed [SAMPLE_BITS-1:0] coef_nxt,
	input  logic signed [SAMPLE_BITS-1:0] smp_nxt,
	input  logic signed [SAMPLE_BITS-1:0] smp_prv,
	output logic signed [SAMPLE_BITS-1:0] coef,
	output logic signed [SAMPLE_BITS-1:0] smp
);

	localparam logic signed [SAMPLE_BITS-1:0] COEF_RST =
		(SAMPLE_BITS)'(1) << (SAMPLE_BITS - 3);

	logic signed [SAMPLE_BITS-1:0] coef_q;
	logic signed [SAMPLE_BITS-1:0] smp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RST;
			smp_q  <= '0;
		end else if (ctl.rotate) begin
			coef_q <= coef_nxt;
			smp_q  <= smp_nxt;
		end else if (ctl.shift) begin
			smp_q  <= smp_prv;
		end
	end

	assign coef = coef_q;
	assign smp  = smp_q;

endmodule

/* rtl/core/firpt_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firpt_mac
// multiply-accumulate unit at the head of the cell ring, with a saturating
// wide accumulator and round-half-up saturation to the sample width
// ----------------------------------------------------------------------------
module firpt_mac #(
	parameter int SAMPLE_BITS = firpt_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  firpt_pkg::mac_ctrl_t          ctl,
	input  logic signed [SAMPLE_BITS-1:0] coef,
	input  logic signed [SAMPLE_BITS-1:0] smp,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int ACC_W = firpt_pkg::ACC_W;
	localparam int FR    = SAMPLE_BITS - 1;
	localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'(1) << (SAMPLE_BITS - 2);
	localparam logic signed [ACC_W:0] HI   = ((ACC_W+1)'(1) << FR) - (ACC_W+1)'(1);
	localparam logic signed [ACC_W:0] LO   = -HI - (ACC_W+1)'(1);

	logic signed [2*SAMPLE_BITS-1:0] prod_s1;
	logic                            vld_s1;
	logic signed [ACC_W-1:0]         acc_q;
	logic signed [ACC_W:0]           sum_w;
	logic signed [ACC_W:0]           rnd_w;
	logic signed [ACC_W:0]           quo_w;

	assign sum_w = (ACC_W+1)'(acc_q) + (ACC_W+1)'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			prod_s1 <= '0;
			acc_q   <= '0;
		end else begin
			vld_s1  <= ctl.mac_en;
			prod_s1 <= coef * smp;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (vld_s1) begin
				// saturate at the accumulator bounds
				if (sum_w[ACC_W] != sum_w[ACC_W-1]) begin
					acc_q <= sum_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
					                      : {1'b0, {(ACC_W-1){1'b1}}};
				end else begin
					acc_q <= sum_w[ACC_W-1:0];
				end
			end
		end
	end

	assign rnd_w = (ACC_W+1)'(acc_q) + HALF;
	assign quo_w = rnd_w >>> FR;

	always_comb begin
		if (quo_w > HI) begin
			result = HI[SAMPLE_BITS-1:0];
		end else if (quo_w < LO) begin
			result = LO[SAMPLE_BITS-1:0];
		end else begin
			result = quo_w[SAMPLE_BITS-1:0];
		end
	end

endmodule

/* rtl/core/fir_filter_programmable_taps_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_programmable_taps_top
// direct-form fir filter with programmable coefficients on a ring of tap cells
// ----------------------------------------------------------------------------
// Each tap lives in a cell holding its coefficient and delayed sample. For
// every beat the ring rotates once all the way around, moving each tap past
// a single multiply-accumulate at the head; a sample beat then shifts the
// new sample into the delay line, a coefficient write is applied as its tap
// passes the head. After the rotation and the shift state the result is
// written to the output register once it is free, and the next beat can be
// taken after that, so the beat rate is set by the ring rotation through the
// one shared multiplier. The output lags the input by one sample. The result
// register lets the next beat be accepted while a result still waits.
// ----------------------------------------------------------------------------
module fir_filter_programmable_taps_top #(
	parameter int TAPS        = firpt_pkg::TAPS_DEF,
	parameter int SAMPLE_BITS = firpt_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            cfg_wen,
	input  logic [firpt_pkg::TC_W-1:0]                      cfg_wdata,
	input  logic                                            s_tvalid,
	output logic                                            s_tready,
	// sample_in, coeff_index, coeff_value, zero pad
	input  logic [((2*SAMPLE_BITS+firpt_pkg::IDX_W+7)/8)*8-1:0] s_tdata,
	// op
	input  logic                                            s_tuser,
	output logic                                            m_tvalid,
	input  logic                                            m_tready,
	// sample_out, coeff_readback, zero pad
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]              m_tdata,
	// index_error
	output logic                                            m_tuser
);

	localparam int IDX_W  = firpt_pkg::IDX_W;
	localparam int TC_W   = firpt_pkg::TC_W;
	localparam int OUT_W  = ((2*SAMPLE_BITS+7)/8)*8;
	localparam int STEP_W = $clog2(TAPS);
	localparam int N_W    = $clog2(TAPS+1);
	localparam int CW     = (TC_W > N_W) ? TC_W : N_W;

	typedef enum logic [1:0] {S_IDLE, S_ROT, S_SHIFT, S_DONE} state_t;

	state_t                        state_q;
	logic [TC_W-1:0]               tap_count_q;
	logic                          op_q;
	logic signed [SAMPLE_BITS-1:0] smp_in_q;
	logic [IDX_W-1:0]              idx_q;
	logic signed [SAMPLE_BITS-1:0] val_q;
	logic                          err_q;
	logic signed [SAMPLE_BITS-1:0] rb_q;
	logic [STEP_W-1:0]             step_q;
	logic                          m_valid_q;
	logic signed [SAMPLE_BITS-1:0] so_q;
	logic signed [SAMPLE_BITS-1:0] rbo_q;
	logic                          erro_q;

	logic [CW-1:0]                 tc_ext;
	logic [CW-1:0]                 n_w;
	logic                          accept;
	logic                          at_idx;
	logic                          wr_hit;
	logic                          out_free;
	logic signed [SAMPLE_BITS-1:0] coef_ring_in;
	logic signed [SAMPLE_BITS-1:0] mac_res;
	logic [IDX_W-1:0]              in_idx;

	firpt_pkg::cell_ctrl_t cell_ctl;
	firpt_pkg::mac_ctrl_t  mac_ctl;

	logic signed [SAMPLE_BITS-1:0] coef_w [TAPS];
	logic signed [SAMPLE_BITS-1:0] smp_w  [TAPS];

	// effective tap count, clamped into 1..TAPS
	assign tc_ext = CW'(tap_count_q);
	always_comb begin
		if (tc_ext == '0) begin
			n_w = CW'(1);
		end else if (tc_ext > CW'(TAPS)) begin
			n_w = CW'(TAPS);
		end else begin
			n_w = tc_ext;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign in_idx   = s_tdata[SAMPLE_BITS+IDX_W-1:SAMPLE_BITS];

	assign at_idx       = (state_q == S_ROT) && (op_q == firpt_pkg::OP_WRITE) &&
	                      (CW'(step_q) == CW'(idx_q));
	assign wr_hit       = at_idx && !err_q;
	assign coef_ring_in = wr_hit ? val_q : coef_w[0];

	assign cell_ctl.rotate = (state_q == S_ROT);
	assign cell_ctl.shift  = (state_q == S_SHIFT) && (op_q == firpt_pkg::OP_SAMPLE);

	assign mac_ctl.clear  = accept;
	assign mac_ctl.mac_en = (state_q == S_ROT) && (op_q == firpt_pkg::OP_SAMPLE) &&
	                        (CW'(step_q) < n_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= firpt_pkg::TC_RESET;
		end else if (cfg_wen) begin
			tap_count_q <= cfg_wdata;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < TAPS; gi++) begin : g_cell
			logic signed [SAMPLE_BITS-1:0] coef_nxt;
			logic signed [SAMPLE_BITS-1:0] smp_nxt;
			logic signed [SAMPLE_BITS-1:0] smp_prv;
			if (gi == TAPS-1) begin : g_tail
				assign coef_nxt = coef_ring_in;
				assign smp_nxt  = smp_w[0];
			end else begin : g_body
				assign coef_nxt = coef_w[gi+1];
				assign smp_nxt  = smp_w[gi+1];
			end
			if (gi == 0) begin : g_head
				assign smp_prv = smp_in_q;
			end else begin : g_rest
				assign smp_prv = smp_w[gi-1];
			end
			firpt_cell #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (cell_ctl),
				.coef_nxt(coef_nxt),
				.smp_nxt (smp_nxt),
				.smp_prv (smp_prv),
				.coef    (coef_w[gi]),
				.smp     (smp_w[gi])
			);
		end
	endgenerate

	firpt_mac #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.coef  (coef_w[0]),
		.smp   (smp_w[0]),
		.result(mac_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= firpt_pkg::OP_SAMPLE;
			smp_in_q  <= '0;
			idx_q     <= '0;
			val_q     <= '0;
			err_q     <= 1'b0;
			rb_q      <= '0;
			step_q    <= '0;
			m_valid_q <= 1'b0;
			so_q      <= '0;
			rbo_q     <= '0;
			erro_q    <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && (state_q != S_DONE)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= s_tuser;
						smp_in_q <= s_tdata[SAMPLE_BITS-1:0];
						idx_q    <= in_idx;
						val_q    <= s_tdata[2*SAMPLE_BITS+IDX_W-1:SAMPLE_BITS+IDX_W];
						err_q    <= (s_tuser == firpt_pkg::OP_WRITE) &&
						            (CW'(in_idx) >= n_w);
						rb_q     <= '0;
						step_q   <= '0;
						state_q  <= S_ROT;
					end
				end
				S_ROT: begin
					if (at_idx) begin
						rb_q <= coef_ring_in;
					end
					if (step_q == STEP_W'(TAPS-1)) begin
						state_q <= S_SHIFT;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_SHIFT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						if (op_q == firpt_pkg::OP_SAMPLE) begin
							so_q   <= mac_res;
							rbo_q  <= '0;
							erro_q <= 1'b0;
						end else begin
							so_q   <= '0;
							rbo_q  <= rb_q;
							erro_q <= err_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'({rbo_q, so_q});
	assign m_tuser  = erro_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input accepted again while a beat is in flight");

	a_mac_only_on_samples: assert property (@(posedge clk) disable iff (!arst_n)
		mac_ctl.mac_en |-> (state_q == S_ROT && op_q == firpt_pkg::OP_SAMPLE))
		else $error("accumulate outside a sample rotation");

	a_sample_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free && op_q == firpt_pkg::OP_SAMPLE) |=>
		(m_tvalid && !m_tuser && rbo_q == '0))
		else $error("sample beat carries readback or error");

	a_write_no_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.shift |-> (op_q == firpt_pkg::OP_SAMPLE && !cell_ctl.rotate))
		else $error("delay line shifted on a coefficient write");
`endif

endmodule

/* tb/sv/fir_filter_programmable_taps_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_programmable_taps_checker
// prediction and comparison for the programmable-tap fir filter
// ----------------------------------------------------------------------------
// Watches the register port and both stream channels. Every beat accepted on
// the slave side is run through a local copy of the filter state (tap count,
// delay line, coefficient store) and the expected result is queued. Every
// beat on the master side is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module fir_filter_programmable_taps_checker #(
	parameter int TAPS = firpt_pkg::TAPS_DEF,
	parameter int SB   = firpt_pkg::SAMPLE_BITS_DEF,
	parameter int S_W  = ((2*SB+firpt_pkg::IDX_W+7)/8)*8,
	parameter int M_W  = ((2*SB+7)/8)*8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [firpt_pkg::TC_W-1:0] cfg_wdata,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [S_W-1:0]             s_tdata,
	input  logic                       s_tuser,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [M_W-1:0]             m_tdata,
	input  logic                       m_tuser,
	output int                         fails,
	output int                         pending,
	output int                         checked
);
	import firpt_pkg::*;

	localparam longint OUT_MAX = (longint'(1) <<< (SB-1)) - 1;
	localparam longint OUT_MIN = -(longint'(1) <<< (SB-1));
	localparam longint HALF_LSB = longint'(1) <<< (SB-2);

	typedef struct packed {
		logic [SB-1:0] sample_out;
		logic [SB-1:0] coeff_readback;
		logic          index_error;
	} filter_out_t;

	logic [TC_W-1:0]      tap_count_m;
	logic signed [SB-1:0] delay_line_m [TAPS];
	logic signed [SB-1:0] coeff_store_m [TAPS];
	filter_out_t          awaited_outputs [$];

	initial begin
		fails   = 0;
		pending = 0;
		checked = 0;
	end

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fails++;
	endtask

	function automatic int active_taps(input logic [TC_W-1:0] t);
		if (t == 0)
			return 1;
		if (int'(t) > TAPS)
			return TAPS;
		return int'(t);
	endfunction

	task automatic compute_filter_output(input logic op, input logic [S_W-1:0] d);
		filter_out_t          r;
		int                   n;
		longint               acc;
		logic signed [SB-1:0] smp;
		logic [IDX_W-1:0]     idx;
		logic signed [SB-1:0] val;
		smp = d[SB-1:0];
		idx = d[SB+IDX_W-1:SB];
		val = d[2*SB+IDX_W-1:SB+IDX_W];
		n   = active_taps(tap_count_m);
		r   = '0;
		if (op == OP_SAMPLE) begin
			acc = 0;
			for (int k = 0; k < n; k++)
				acc += longint'(coeff_store_m[k]) * longint'(delay_line_m[k]);
			acc = (acc + HALF_LSB) >>> (SB-1);
			if (acc > OUT_MAX)
				acc = OUT_MAX;
			else if (acc < OUT_MIN)
				acc = OUT_MIN;
			r.sample_out = acc[SB-1:0];
			for (int i = TAPS-1; i > 0; i--)
				delay_line_m[i] = delay_line_m[i-1];
			delay_line_m[0] = smp;
		end else begin
			r.index_error = (int'(idx) >= n);
			if (!r.index_error)
				coeff_store_m[idx] = val;
			if (int'(idx) < TAPS)
				r.coeff_readback = coeff_store_m[idx];
		end
		awaited_outputs.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		filter_out_t want;
		if (!arst_n) begin
			tap_count_m = TC_RESET;
			for (int i = 0; i < TAPS; i++) begin
				delay_line_m[i]  = '0;
				coeff_store_m[i] = SB'(1 << (SB-3));
			end
			awaited_outputs.delete();
			pending = 0;
		end else begin
			if (cfg_wen)
				tap_count_m = cfg_wdata;
			if (s_tvalid && s_tready)
				compute_filter_output(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				checked++;
				if (awaited_outputs.size() == 0) begin
					report($sformatf("result beat with nothing expected (data %h, user %b)",
						m_tdata, m_tuser));
				end else begin
					want = awaited_outputs.pop_front();
					if (m_tdata[SB-1:0] !== want.sample_out)
						report($sformatf("sample_out got %0d, expected %0d",
							$signed(m_tdata[SB-1:0]), $signed(want.sample_out)));
					if (m_tdata[2*SB-1:SB] !== want.coeff_readback)
						report($sformatf("coeff_readback got %0d, expected %0d",
							$signed(m_tdata[2*SB-1:SB]), $signed(want.coeff_readback)));
					if (m_tuser !== want.index_error)
						report($sformatf("index_error got %b, expected %b",
							m_tuser, want.index_error));
				end
			end
			pending = awaited_outputs.size();
		end
	end

endmodule

/* tb/sv/fir_filter_programmable_taps_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_programmable_taps_top_test
// stimulus and verdict for the programmable-tap fir filter
// ----------------------------------------------------------------------------
// Drives sample and coefficient-write beats through the stream port over a
// series of tap-count settings, starting with a short directed run (reset
// coefficients, saturation both ways, rounding ties, out-of-range writes)
// and then random traffic. Sender gaps and receiver stalls vary per phase.
// Checking is done by the checker module alongside the block.
// ----------------------------------------------------------------------------
module fir_filter_programmable_taps_top_test;
	import firpt_pkg::*;

	localparam int TAPS  = TAPS_DEF;
	localparam int SB    = SAMPLE_BITS_DEF;
	localparam int S_W   = ((2*SB+IDX_W+7)/8)*8;
	localparam int M_W   = ((2*SB+7)/8)*8;
	localparam int LIMIT = 4000;
	localparam int PHASE_BEATS = 200;

	localparam logic [SB-1:0] Q_MAX  = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] Q_MIN  = {1'b1, {(SB-1){1'b0}}};
	localparam logic [SB-1:0] Q_HALF = SB'(1 << (SB-2));

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_wen   = 1'b0;
	logic [TC_W-1:0]  cfg_wdata = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [S_W-1:0]   s_tdata   = '0;
	logic             s_tuser   = 1'b0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [M_W-1:0]   m_tdata;
	logic             m_tuser;

	int               fails;
	int               pending;
	int               checked;
	int               idle_pct  = 0;
	int               stall_pct = 0;
	int               stall_run = 0;
	int               quiet_cycles = 0;
	int               beats     = 0;
	int               writes    = 0;
	int               settings  = 0;
	logic [TC_W-1:0]  cur_taps  = TC_RESET;

	always #5 clk = ~clk;

	fir_filter_programmable_taps_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	fir_filter_programmable_taps_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.fails     (fails),
		.pending   (pending),
		.checked   (checked)
	);

	// receiver: per-cycle stalls with an occasional long hold
	always @(negedge clk) begin
		if (stall_run > 0) begin
			stall_run <= stall_run - 1;
			m_tready  <= 1'b0;
		end else if ($urandom_range(99) < stall_pct) begin
			m_tready <= 1'b0;
			if ($urandom_range(15) == 0)
				stall_run <= $urandom_range(80, 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= LIMIT) begin
			$display("[%0t] watchdog: no beat moved for %0d cycles", $realtime, LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [S_W-1:0] pack_beat(input logic [SB-1:0] smp,
		input logic [IDX_W-1:0] idx, input logic [SB-1:0] val);
		logic [S_W-1:0] d;
		d = '0;
		d[SB-1:0]                 = smp;
		d[SB+IDX_W-1:SB]          = idx;
		d[2*SB+IDX_W-1:SB+IDX_W]  = val;
		return d;
	endfunction

	function automatic logic [SB-1:0] rand_q15();
		logic [SB-1:0] v;
		int            t;
		t = $urandom_range(511);
		case ($urandom_range(7))
			0:       v = Q_MIN;
			1:       v = Q_MAX;
			2:       v = '0;
			3:       v = SB'(t - 256);
			default: v = SB'($urandom);
		endcase
		return v;
	endfunction

	// returns right after the accepting edge so valid can stay high for the next beat
	task automatic send_beat(input logic op, input logic [S_W-1:0] d);
		int gap;
		gap = 0;
		if ($urandom_range(99) < idle_pct)
			gap = ($urandom_range(3) == 0) ? $urandom_range(90, 1) : $urandom_range(4, 1);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats++;
		if (op == OP_WRITE)
			writes++;
	endtask

	task automatic send_sample(input logic [SB-1:0] smp);
		send_beat(OP_SAMPLE, pack_beat(smp, IDX_W'($urandom), SB'($urandom)));
	endtask

	task automatic send_write(input logic [IDX_W-1:0] idx, input logic [SB-1:0] val);
		send_beat(OP_WRITE, pack_beat(SB'($urandom), idx, val));
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (TAPS + 8) @(negedge clk);
	endtask

	task automatic set_taps(input logic [TC_W-1:0] v, input int mode);
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		cur_taps  = v;
		settings++;
		case (mode)
			0:       begin idle_pct = 0;  stall_pct = 0;  end
			1:       begin idle_pct = 62; stall_pct = 0;  end
			2:       begin idle_pct = 0;  stall_pct = 62; end
			default: begin idle_pct = 21; stall_pct = 21; end
		endcase
	endtask

	task automatic send_random();
		int n;
		logic [IDX_W-1:0] idx;
		n = (cur_taps == 0) ? 1 : ((int'(cur_taps) > TAPS) ? TAPS : int'(cur_taps));
		if ($urandom_range(3) == 0) begin
			if ($urandom_range(9) < 7)
				idx = IDX_W'($urandom_range(n - 1));
			else
				idx = IDX_W'($urandom);
			send_write(idx, rand_q15());
		end else begin
			send_sample(rand_q15());
		end
	endtask

	initial begin
		logic [TC_W-1:0] plan [8];
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset coefficients with the reset tap count, then a write past it
		repeat (4) send_sample(Q_MAX);
		send_sample(Q_MIN);
		send_write(IDX_W'(3), Q_MAX);
		send_write(IDX_W'(4), Q_MIN);

		// single tap: positive saturation and writes beyond the active taps
		set_taps(TC_W'(1), 0);
		send_write(IDX_W'(0), Q_MIN);
		send_write(IDX_W'(1), Q_MAX);
		send_write(IDX_W'(TAPS - 1), Q_MAX);
		send_sample(Q_MIN);
		send_sample(Q_MIN);
		send_sample(Q_MAX);
		send_sample('0);

		// two taps: negative saturation, then rounding ties
		set_taps(TC_W'(2), 0);
		send_write(IDX_W'(0), Q_MIN);
		send_write(IDX_W'(1), Q_MIN);
		repeat (3) send_sample(Q_MAX);
		send_write(IDX_W'(0), SB'(1));
		send_write(IDX_W'(1), '0);
		send_sample(Q_HALF);
		send_sample('0);
		send_sample(-Q_HALF);
		send_sample('0);

		plan = '{TC_W'(0), {TC_W{1'b1}}, TC_W'(TAPS), TC_W'(1),
			TC_W'($urandom_range(TAPS - 1, 5)), TC_W'(TAPS),
			TC_W'($urandom_range(126, TAPS + 1)), TC_RESET};
		for (int p = 0; p < 8; p++) begin
			set_taps(plan[p], p % 4);
			repeat (PHASE_BEATS) send_random();
		end

		drain();
		$display("covered %0d input beats (%0d coefficient writes) and %0d results",
			beats, writes, checked);
		$display("over %0d tap-count settings, with sender gaps and receiver stalls",
			settings);
		if (fails == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
